// ===== rtl/core/dtrf_pkg.sv =====
// Shared widths, types and helper function of the direction-to-frame pipeline.
package dtrf_pkg;

	localparam int IN_W        = 24;
	localparam int FRAC        = 14;
	localparam int OUT_W       = FRAC + 2;
	localparam int NORM_MSB    = 29;
	localparam int NM_W        = NORM_MSB + 1;
	localparam int SQ_W        = 2 * NM_W;
	localparam int SUM_W       = SQ_W + 2;
	localparam int ROOT_W      = SUM_W / 2;
	localparam int SQRT_STEPS  = SUM_W / 2 + 1;
	localparam int SQRT_RW     = SUM_W + 2;
	localparam int QUO_W       = FRAC + 1;
	localparam int NUM_W       = NM_W + QUO_W + 1;
	localparam int REM_W       = NUM_W + 1;
	localparam int DEN_W       = ROOT_W + 1;
	localparam int SHIFT_W     = $clog2(NORM_MSB + 1);
	localparam int POS_W       = $clog2(IN_W);
	localparam int FE_LAT      = 4;
	localparam int DIV_LAT     = QUO_W + 2;
	localparam int CROSS_LAT   = 2;
	localparam int LAT         = FE_LAT + SQRT_STEPS + DIV_LAT + CROSS_LAT;
	localparam int PROD_W      = 2 * OUT_W;
	localparam int DIFF_W      = PROD_W + 1;

	typedef logic signed [IN_W-1:0]  dir_t;
	typedef logic signed [OUT_W-1:0] frac_t;
	typedef logic [IN_W-1:0]         mag_t;
	typedef logic [NM_W-1:0]         nm_t;
	typedef logic [SUM_W-1:0]        sum_t;
	typedef logic [ROOT_W-1:0]       root_t;

	typedef enum logic [1:0] {
		SEL_X,
		SEL_Y,
		SEL_Z
	} sel_t;

	typedef struct packed {
		nm_t [2:0]  fm;
		logic [2:0] fneg;
		nm_t [2:0]  sm;
		logic [2:0] sneg;
	} vecs_t;

	function automatic logic [POS_W-1:0] msb_pos(input mag_t v);
		logic [POS_W-1:0] p;
		p = '0;
		for (int i = 0; i < IN_W; i++) begin
			if (v[i]) begin
				p = POS_W'(i);
			end
		end
		return p;
	endfunction

endpackage

// ===== rtl/core/dtrf_isqrt.sv =====
// Pipelined integer square root, one result bit per stage.
module dtrf_isqrt (
	input  logic            clk,
	input  logic            en,
	input  dtrf_pkg::sum_t  n_in,
	output dtrf_pkg::root_t root
);
	import dtrf_pkg::*;

	logic [SQRT_RW-1:0] rem_q  [SQRT_STEPS];
	logic [SQRT_RW-1:0] root_q [SQRT_STEPS];

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
		logic [SQRT_RW-1:0] n_prev;
		logic [SQRT_RW-1:0] r_prev;
		logic [SQRT_RW-1:0] b;
		logic [SQRT_RW-1:0] t;

		if (k == 0) begin : g_first
			assign n_prev = SQRT_RW'(n_in);
			assign r_prev = '0;
		end else begin : g_next
			assign n_prev = rem_q[k-1];
			assign r_prev = root_q[k-1];
		end

		assign b = SQRT_RW'(1) << (2 * (SQRT_STEPS - 1 - k));
		assign t = r_prev + b;

		always_ff @(posedge clk) begin
			if (en) begin
				if (n_prev >= t) begin
					rem_q[k]  <= n_prev - t;
					root_q[k] <= (r_prev >> 1) + b;
				end else begin
					rem_q[k]  <= n_prev;
					root_q[k] <= r_prev >> 1;
				end
			end
		end
	end

	assign root = root_q[SQRT_STEPS-1][ROOT_W-1:0];

endmodule

// ===== rtl/core/dtrf_div.sv =====
// Pipelined restoring divider that scales one component by the vector length.
module dtrf_div (
	input  logic             clk,
	input  logic             en,
	input  dtrf_pkg::nm_t    mag,
	input  dtrf_pkg::root_t  len,
	input  logic             neg,
	output dtrf_pkg::frac_t  quo
);
	import dtrf_pkg::*;

	logic [REM_W-1:0] rem_q [QUO_W+1];
	logic [DEN_W-1:0] den_q [QUO_W+1];
	logic [QUO_W-1:0] acc_q [QUO_W+1];
	logic             neg_q [QUO_W+1];

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q[0] <= (REM_W'(mag) << (FRAC + 1)) + REM_W'(len);
			den_q[0] <= {len, 1'b0};
			acc_q[0] <= '0;
			neg_q[0] <= neg;
		end
	end

	for (genvar k = 1; k <= QUO_W; k++) begin : g_step
		logic [REM_W-1:0] dsh;

		assign dsh = REM_W'(den_q[k-1]) << (QUO_W - k);

		always_ff @(posedge clk) begin
			if (en) begin
				den_q[k] <= den_q[k-1];
				neg_q[k] <= neg_q[k-1];
				if (rem_q[k-1] >= dsh) begin
					rem_q[k] <= rem_q[k-1] - dsh;
					acc_q[k] <= acc_q[k-1] | (QUO_W'(1) << (QUO_W - k));
				end else begin
					rem_q[k] <= rem_q[k-1];
					acc_q[k] <= acc_q[k-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (neg_q[QUO_W]) begin
				quo <= -$signed(OUT_W'(acc_q[QUO_W]));
			end else begin
				quo <= $signed(OUT_W'(acc_q[QUO_W]));
			end
		end
	end

endmodule

// ===== rtl/core/dtrf_cross.sv =====
// Cross product of the forward and side rows with rounding and saturation.
module dtrf_cross (
	input  logic            clk,
	input  logic            en,
	input  dtrf_pkg::frac_t f [3],
	input  dtrf_pkg::frac_t s [3],
	output dtrf_pkg::frac_t u [3]
);
	import dtrf_pkg::*;

	logic signed [PROD_W-1:0] pa_s1 [3];
	logic signed [PROD_W-1:0] pb_s1 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			pa_s1[0] <= f[1] * s[2];
			pb_s1[0] <= f[2] * s[1];
			pa_s1[1] <= f[2] * s[0];
			pb_s1[1] <= f[0] * s[2];
			pa_s1[2] <= f[0] * s[1];
			pb_s1[2] <= f[1] * s[0];
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_lane
		logic signed [DIFF_W-1:0] diff;
		logic [DIFF_W-1:0]        mag;
		logic [DIFF_W-1:0]        rnd;
		logic [OUT_W-1:0]         sat;

		always_comb begin
			diff = DIFF_W'(pa_s1[i]) - DIFF_W'(pb_s1[i]);
			mag  = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
			rnd  = (mag + (DIFF_W'(1) << (FRAC - 1))) >> FRAC;
			if (rnd > (DIFF_W'(1) << FRAC)) begin
				sat = OUT_W'(1) << FRAC;
			end else begin
				sat = rnd[OUT_W-1:0];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				u[i] <= diff[DIFF_W-1] ? -$signed(sat) : $signed(sat);
			end
		end
	end

endmodule

// ===== rtl/core/direction_to_rotation_frame_top.sv =====
// Top level of the direction-to-orthonormal-frame pipeline.
// The block takes one direction vector per cycle while in_ready is high and returns its frame
// (forward, side and up rows in Q2.14), one frame per cycle while out_ready stays high. The
// pipeline is built from a 4-stage front end, a 32-stage square root, a 17-stage divider and
// a 2-stage cross product. A stall on the output holds the whole pipeline. A zero input vector
// gives all zeros with degenerate set.
module direction_to_rotation_frame_top (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  dtrf_pkg::dir_t  dir_x,
	input  dtrf_pkg::dir_t  dir_y,
	input  dtrf_pkg::dir_t  dir_z,
	output logic            out_valid,
	input  logic            out_ready,
	output dtrf_pkg::frac_t fwd_x,
	output dtrf_pkg::frac_t fwd_y,
	output dtrf_pkg::frac_t fwd_z,
	output dtrf_pkg::frac_t side_x,
	output dtrf_pkg::frac_t side_y,
	output dtrf_pkg::frac_t side_z,
	output dtrf_pkg::frac_t up_x,
	output dtrf_pkg::frac_t up_y,
	output dtrf_pkg::frac_t up_z,
	output logic            degenerate
);
	import dtrf_pkg::*;

	logic             adv;
	logic [LAT-1:0]   vld_q;
	logic [LAT-1:0]   deg_q;
	dir_t             dir_in [3];
	mag_t             mag_s1 [3];
	logic [2:0]       neg_s1;
	mag_t             mx;
	logic [SHIFT_W-1:0] sh;
	vecs_t            vec_s2, vec_s3, vec_s4;
	sel_t             sel_s2, sel_s3;
	logic [SQ_W-1:0]  sq_s3 [3];
	sum_t             fsum_s4, ssum_s4;
	vecs_t            dly_q [SQRT_STEPS];
	root_t            flen, slen;
	frac_t            fq [3];
	frac_t            sq [3];
	frac_t            uv [3];
	frac_t            fwd_d1_q [3];
	frac_t            fwd_d2_q [3];
	frac_t            side_d1_q [3];
	frac_t            side_d2_q [3];

	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;
	assign dir_in[0] = dir_x;
	assign dir_in[1] = dir_y;
	assign dir_in[2] = dir_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			deg_q <= {deg_q[LAT-2:0], (dir_x == '0) && (dir_y == '0) && (dir_z == '0)};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				neg_s1[i] <= dir_in[i][IN_W-1];
				mag_s1[i] <= dir_in[i][IN_W-1] ? mag_t'(-dir_in[i]) : mag_t'(dir_in[i]);
			end
		end
	end

	always_comb begin
		mx = mag_s1[0];
		if (mag_s1[1] > mx) begin
			mx = mag_s1[1];
		end
		if (mag_s1[2] > mx) begin
			mx = mag_s1[2];
		end
		sh = SHIFT_W'(NORM_MSB) - SHIFT_W'(msb_pos(mx));
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				vec_s2.fm[i] <= nm_t'(mag_s1[i]) << sh;
			end
			vec_s2.fneg <= neg_s1;
			if (mag_s1[0] < mag_s1[1] && mag_s1[0] < mag_s1[2]) begin
				sel_s2         <= SEL_X;
				vec_s2.sm[0]   <= '0;
				vec_s2.sm[1]   <= nm_t'(mag_s1[2]) << sh;
				vec_s2.sm[2]   <= nm_t'(mag_s1[1]) << sh;
				vec_s2.sneg    <= {neg_s1[1], !neg_s1[2], 1'b0};
			end else if (mag_s1[1] < mag_s1[2]) begin
				sel_s2         <= SEL_Y;
				vec_s2.sm[0]   <= nm_t'(mag_s1[2]) << sh;
				vec_s2.sm[1]   <= '0;
				vec_s2.sm[2]   <= nm_t'(mag_s1[0]) << sh;
				vec_s2.sneg    <= {neg_s1[0], 1'b0, !neg_s1[2]};
			end else begin
				sel_s2         <= SEL_Z;
				vec_s2.sm[0]   <= nm_t'(mag_s1[1]) << sh;
				vec_s2.sm[1]   <= nm_t'(mag_s1[0]) << sh;
				vec_s2.sm[2]   <= '0;
				vec_s2.sneg    <= {1'b0, neg_s1[0], !neg_s1[1]};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				sq_s3[i] <= vec_s2.fm[i] * vec_s2.fm[i];
			end
			vec_s3 <= vec_s2;
			sel_s3 <= sel_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fsum_s4 <= sum_t'(sq_s3[0]) + sum_t'(sq_s3[1]) + sum_t'(sq_s3[2]);
			unique case (sel_s3)
				SEL_X:   ssum_s4 <= sum_t'(sq_s3[1]) + sum_t'(sq_s3[2]);
				SEL_Y:   ssum_s4 <= sum_t'(sq_s3[0]) + sum_t'(sq_s3[2]);
				SEL_Z:   ssum_s4 <= sum_t'(sq_s3[0]) + sum_t'(sq_s3[1]);
				default: ssum_s4 <= '0;
			endcase
			vec_s4 <= vec_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dly_q[0] <= vec_s4;
			for (int k = 1; k < SQRT_STEPS; k++) begin
				dly_q[k] <= dly_q[k-1];
			end
		end
	end

	dtrf_isqrt u_sqrt_fwd (
		.clk  (clk),
		.en   (adv),
		.n_in (fsum_s4),
		.root (flen)
	);

	dtrf_isqrt u_sqrt_side (
		.clk  (clk),
		.en   (adv),
		.n_in (ssum_s4),
		.root (slen)
	);

	for (genvar i = 0; i < 3; i++) begin : g_div
		dtrf_div u_div_fwd (
			.clk (clk),
			.en  (adv),
			.mag (dly_q[SQRT_STEPS-1].fm[i]),
			.len (flen),
			.neg (dly_q[SQRT_STEPS-1].fneg[i]),
			.quo (fq[i])
		);

		dtrf_div u_div_side (
			.clk (clk),
			.en  (adv),
			.mag (dly_q[SQRT_STEPS-1].sm[i]),
			.len (slen),
			.neg (dly_q[SQRT_STEPS-1].sneg[i]),
			.quo (sq[i])
		);
	end

	dtrf_cross u_cross (
		.clk (clk),
		.en  (adv),
		.f   (fq),
		.s   (sq),
		.u   (uv)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			fwd_d1_q  <= fq;
			fwd_d2_q  <= fwd_d1_q;
			side_d1_q <= sq;
			side_d2_q <= side_d1_q;
		end
	end

	assign out_valid  = vld_q[LAT-1];
	assign degenerate = deg_q[LAT-1];
	assign fwd_x  = degenerate ? '0 : fwd_d2_q[0];
	assign fwd_y  = degenerate ? '0 : fwd_d2_q[1];
	assign fwd_z  = degenerate ? '0 : fwd_d2_q[2];
	assign side_x = degenerate ? '0 : side_d2_q[0];
	assign side_y = degenerate ? '0 : side_d2_q[1];
	assign side_z = degenerate ? '0 : side_d2_q[2];
	assign up_x   = degenerate ? '0 : uv[0];
	assign up_y   = degenerate ? '0 : uv[1];
	assign up_z   = degenerate ? '0 : uv[2];

endmodule

// ===== rtl/core/dtrf_checker.sv =====
// Port-level checks of the direction-to-frame block and their binding to the top level.
module dtrf_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            in_ready,
	input logic            out_valid,
	input logic            out_ready,
	input dtrf_pkg::frac_t fwd_x,
	input dtrf_pkg::frac_t side_x,
	input dtrf_pkg::frac_t side_y,
	input dtrf_pkg::frac_t side_z,
	input dtrf_pkg::frac_t up_z,
	input logic            degenerate
);
	import dtrf_pkg::*;

	// An empty output side never blocks a transfer on the input.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled while output is empty");

	a_degenerate_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> fwd_x == '0 && side_x == '0 && up_z == '0)
		else $error("degenerate result is not zero");

	a_side_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !degenerate |-> side_x != '0 || side_y != '0 || side_z != '0)
		else $error("side row is zero for a nonzero input");

	a_fwd_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $signed(fwd_x) <= $signed(OUT_W'(1) << FRAC)
			&& $signed(fwd_x) >= -$signed(OUT_W'(1) << FRAC))
		else $error("forward component out of range");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(fwd_x) && $stable(up_z))
		else $error("stalled result changed");

endmodule

bind direction_to_rotation_frame_top dtrf_checker u_dtrf_checker (.*);

// ===== tb/sv/direction_to_rotation_frame_top_tb.sv =====
// Self-checking testbench of the direction-to-frame pipeline with a predictor and random stalls.
module direction_to_rotation_frame_top_tb;
	import dtrf_pkg::*;

	typedef struct {
		frac_t fx, fy, fz, sx, sy, sz, ux, uy, uz;
		logic  degen;
	} frame_t;

	typedef struct {
		dir_t   x, y, z;
		logic   known;
		frame_t res;
	} vec_row_t;

	logic  clk;
	logic  arst_n;
	logic  in_valid;
	logic  in_ready;
	dir_t  dir_x, dir_y, dir_z;
	logic  out_valid;
	logic  out_ready;
	frac_t fwd_x, fwd_y, fwd_z, side_x, side_y, side_z, up_x, up_y, up_z;
	logic  degenerate;

	frame_t pending_frames[$];
	int     error_count;
	int     sent_count;
	int     hold_long;

	direction_to_rotation_frame_top u_top (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z), .out_valid(out_valid),
		.out_ready(out_ready), .fwd_x(fwd_x), .fwd_y(fwd_y), .fwd_z(fwd_z),
		.side_x(side_x), .side_y(side_y), .side_z(side_z), .up_x(up_x),
		.up_y(up_y), .up_z(up_z), .degenerate(degenerate)
	);

	initial begin
		clk = 1'b0;
	end

	always #5 clk = ~clk;

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic void normalize(input longint v[3], output longint q[3]);
		longint unsigned m[3], s, len, r;
		s = 0;
		for (int i = 0; i < 3; i++) begin
			m[i] = v[i] < 0 ? -v[i] : v[i];
			s += m[i] * m[i];
		end
		len = int_sqrt(s);
		for (int i = 0; i < 3; i++) begin
			r = 0;
			if (len != 0) r = ((m[i] << (FRAC + 1)) + len) / (len * 2);
			q[i] = v[i] < 0 ? -longint'(r) : longint'(r);
		end
	endfunction

	function automatic frac_t cross_part(longint a, longint b, longint c, longint d);
		longint diff;
		longint unsigned m, r;
		diff = a * b - c * d;
		m = diff < 0 ? -diff : diff;
		r = (m + (64'd1 << (FRAC - 1))) >> FRAC;
		if (r > (64'd1 << FRAC)) r = 64'd1 << FRAC;
		return frac_t'(diff < 0 ? -longint'(r) : longint'(r));
	endfunction

	function automatic frame_t predict_frame(dir_t x, dir_t y, dir_t z);
		frame_t f;
		longint d[3], v[3], sv[3], fw[3], sd[3];
		longint unsigned m[3], mx;
		d[0] = x;
		d[1] = y;
		d[2] = z;
		for (int i = 0; i < 3; i++) m[i] = d[i] < 0 ? -d[i] : d[i];
		mx = m[0];
		if (m[1] > mx) mx = m[1];
		if (m[2] > mx) mx = m[2];
		f = '{default: '0};
		if (mx == 0) begin
			f.degen = 1'b1;
			return f;
		end
		while (mx < (64'd1 << NORM_MSB)) begin
			mx <<= 1;
			for (int i = 0; i < 3; i++) m[i] <<= 1;
		end
		for (int i = 0; i < 3; i++) v[i] = d[i] < 0 ? -longint'(m[i]) : longint'(m[i]);
		if (m[0] < m[1] && m[0] < m[2]) begin
			sv[0] = 0; sv[1] = -v[2]; sv[2] = v[1];
		end else if (m[1] < m[2]) begin
			sv[0] = -v[2]; sv[1] = 0; sv[2] = v[0];
		end else begin
			sv[0] = -v[1]; sv[1] = v[0]; sv[2] = 0;
		end
		normalize(v, fw);
		normalize(sv, sd);
		f.fx = frac_t'(fw[0]); f.fy = frac_t'(fw[1]); f.fz = frac_t'(fw[2]);
		f.sx = frac_t'(sd[0]); f.sy = frac_t'(sd[1]); f.sz = frac_t'(sd[2]);
		f.ux = cross_part(fw[1], sd[2], fw[2], sd[1]);
		f.uy = cross_part(fw[2], sd[0], fw[0], sd[2]);
		f.uz = cross_part(fw[0], sd[1], fw[1], sd[0]);
		f.degen = 1'b0;
		return f;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		error_count++;
	endtask

	function automatic int pick_gap();
		if ($urandom_range(0, 3) == 0) return 0;
		if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
		return $urandom_range(0, 3);
	endfunction

	function automatic dir_t rand_comp();
		case ($urandom_range(0, 5))
			0: return dir_t'(int'($urandom_range(0, 6)) - 3);
			1: return dir_t'(int'($urandom_range(0, 2000)) - 1000);
			2: return $urandom_range(0, 1) ? dir_t'(24'h7FFFFF) : dir_t'(24'h800000);
			default: return dir_t'($urandom);
		endcase
	endfunction

	task automatic send_vec(dir_t x, dir_t y, dir_t z);
		in_valid <= 1'b1;
		dir_x <= x;
		dir_y <= y;
		dir_z <= z;
		pending_frames.push_back(predict_frame(x, y, z));
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sent_count++;
	endtask

	task automatic idle_sender(int n);
		if (n == 0) return;
		in_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	initial begin
		vec_row_t rows[$];
		frame_t   zero_frame, unit_frame;
		zero_frame = '{default: '0};
		zero_frame.degen = 1'b1;
		unit_frame = '{default: '0};
		unit_frame.fx = frac_t'(16384);
		unit_frame.sy = frac_t'(16384);
		unit_frame.uz = frac_t'(16384);
		rows = '{
			'{0, 0, 0, 1'b1, zero_frame},
			'{1, 0, 0, 1'b1, unit_frame},
			'{24'h7FFFFF, 0, 0, 1'b1, unit_frame},
			'{24'h800000, 0, 0, 1'b0, zero_frame},
			'{0, 1, 0, 1'b0, zero_frame},
			'{0, 0, 24'h800000, 1'b0, zero_frame},
			'{24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b0, zero_frame},
			'{24'h800000, 24'h800000, 24'h800000, 1'b0, zero_frame},
			'{24'h800000, 24'h7FFFFF, 1, 1'b0, zero_frame},
			'{-1, -1, -1, 1'b0, zero_frame},
			'{1, 2, 3, 1'b0, zero_frame},
			'{3, 2, 1, 1'b0, zero_frame},
			'{2, 1, 3, 1'b0, zero_frame},
			'{1, 1, 5, 1'b0, zero_frame},
			'{5, 1, 1, 1'b0, zero_frame},
			'{2, 2, 2, 1'b0, zero_frame},
			'{-7, 3, 3, 1'b0, zero_frame},
			'{0, 0, -1, 1'b0, zero_frame},
			'{24'h555555, 24'hAAAAAA, 24'h0F0F0F, 1'b0, zero_frame},
			'{1, 24'h7FFFFF, -1, 1'b0, zero_frame}
		};
		arst_n = 1'b0;
		in_valid = 1'b0;
		dir_x = '0;
		dir_y = '0;
		dir_z = '0;
		error_count = 0;
		sent_count = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (rows[i]) begin
			send_vec(rows[i].x, rows[i].y, rows[i].z);
			if (rows[i].known) pending_frames[$] = rows[i].res;
			idle_sender($urandom_range(0, 2));
		end
		for (int n = 0; n < 700; n++) begin
			if (n == 300) begin
				idle_sender(1);
				while (pending_frames.size() != 0) @(posedge clk);
			end
			send_vec(rand_comp(), rand_comp(), rand_comp());
			if (n < 100 || n > 200) idle_sender(pick_gap());
		end
		in_valid <= 1'b0;
		while (pending_frames.size() != 0) @(posedge clk);
		repeat (LAT + 10) @(posedge clk);
		if (error_count == 0) begin
			$display("direction_to_rotation_frame_top_tb: clean");
		end else begin
			$display("direction_to_rotation_frame_top_tb: errors");
		end
		$finish;
	end

	initial begin
		int gap;
		out_ready = 1'b0;
		@(posedge arst_n);
		while (1) begin
			if (sent_count > 120 && hold_long == 0) begin
				hold_long = 1;
				out_ready <= 1'b0;
				repeat (150) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			gap = (sent_count > 400 && sent_count < 550) ? 0 : pick_gap();
			if (gap != 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		frame_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_frames.size() == 0) begin
				report_mismatch("unexpected transfer", 1, 0);
			end else begin
				want = pending_frames.pop_front();
				if (fwd_x !== want.fx) report_mismatch("fwd_x", int'(fwd_x), int'(want.fx));
				if (fwd_y !== want.fy) report_mismatch("fwd_y", int'(fwd_y), int'(want.fy));
				if (fwd_z !== want.fz) report_mismatch("fwd_z", int'(fwd_z), int'(want.fz));
				if (side_x !== want.sx) report_mismatch("side_x", int'(side_x), int'(want.sx));
				if (side_y !== want.sy) report_mismatch("side_y", int'(side_y), int'(want.sy));
				if (side_z !== want.sz) report_mismatch("side_z", int'(side_z), int'(want.sz));
				if (up_x !== want.ux) report_mismatch("up_x", int'(up_x), int'(want.ux));
				if (up_y !== want.uy) report_mismatch("up_y", int'(up_y), int'(want.uy));
				if (up_z !== want.uz) report_mismatch("up_z", int'(up_z), int'(want.uz));
				if (degenerate !== want.degen) begin
					report_mismatch("degenerate", int'(degenerate), int'(want.degen));
				end
			end
		end
	end

	initial begin
		hold_long = 0;
		#2000000;
		$display("direction_to_rotation_frame_top_tb: errors");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/dtrf_pkg.sv
rtl/core/dtrf_isqrt.sv
rtl/core/dtrf_div.sv
rtl/core/dtrf_cross.sv
rtl/core/direction_to_rotation_frame_top.sv
rtl/core/dtrf_checker.sv
tb/sv/direction_to_rotation_frame_top_tb.sv
